/* rtl/core/eogm_pkg.sv */
// Shared widths, types and constant tables for the exposure/offset/gamma map.
package eogm_pkg;

  localparam int SampleBits = 8;
  localparam int FracBits   = 8;
  localparam int QB         = 30;
  localparam int LB         = 24;
  localparam int ExpW       = 12;
  localparam int OffW       = 10;
  localparam int GamW       = 12;
  localparam int IdxW       = 2;
  localparam int MaxV       = (1 << SampleBits) - 1;

  localparam int EiW  = ExpW - FracBits;
  localparam int YW   = QB + 2;
  localparam int MW   = QB + 1;
  localparam int PW   = SampleBits + YW;
  localparam int TW   = PW + (1 << (EiW - 1)) - 1;
  localparam int GW   = TW + 1 - SampleBits;
  localparam int XW   = GW + 1;
  localparam int XSW  = XW + 1;
  localparam int NW   = $clog2(XW);
  localparam int IW   = NW + 1;
  localparam int LW   = IW + LB;
  localparam int DW   = LW + FracBits;
  localparam int LiW  = DW + 1 - LB;
  localparam int SHW  = 7;
  localparam int YSW  = YW + SHW;
  localparam int RW   = YSW + SampleBits;
  localparam int ETabN = 1 << FracBits;

  typedef enum logic [1:0] {
    OVR_NONE,
    OVR_ZERO,
    OVR_FULL
  } ovr_e;

  typedef struct packed {
    logic valid;
    ovr_e ovr;
  } ctl_t;

  typedef enum logic [IdxW-1:0] {
    REG_EXPOSURE,
    REG_OFFSET,
    REG_GAMMA
  } reg_idx_e;

  typedef logic [LB-1:0][YW-1:0]    roots_t;
  typedef logic [ETabN-1:0][YW-1:0] etab_t;

  localparam logic [63:0] HalfQ = 64'(1) << (QB - 1);

  function automatic logic [63:0] isqrt64(logic [63:0] a_in);
    logic [63:0] a;
    logic [63:0] r;
    logic [63:0] b;
    a = a_in;
    r = '0;
    b = 64'(1) << 62;
    for (int i = 0; i < 32; i++) begin
      if (b > a) b = b >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (b != '0) begin
        if (a >= r + b) begin
          a = a - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // r[k] = 2^(2^-(k+1)) in Q30
  function automatic roots_t calc_roots();
    roots_t      rt;
    logic [63:0] cur;
    cur = isqrt64(64'(2) << (2 * QB));
    rt[0] = cur[YW-1:0];
    for (int k = 1; k < LB; k++) begin
      cur = isqrt64(cur << QB);
      rt[k] = cur[YW-1:0];
    end
    return rt;
  endfunction

  localparam roots_t Roots = calc_roots();

  // 2^(i/2^F) in Q30 for every exposure fraction i
  function automatic etab_t calc_etab();
    etab_t       t;
    logic [63:0] y;
    for (int i = 0; i < ETabN; i++) begin
      y = 64'(1) << QB;
      for (int k = 0; k < FracBits; k++) begin
        if (i[FracBits-1-k]) y = (y * 64'(Roots[k]) + HalfQ) >> QB;
      end
      t[i] = y[YW-1:0];
    end
    return t;
  endfunction

  localparam etab_t ExpTab = calc_etab();

endpackage

/* rtl/core/exposure_offset_gamma_map_unit.sv */
// Top level of the exposure, offset and gamma map for one pixel channel.
//
// Usage:
//   Input channel: in_valid_i / in_stall_o with sample_in_i, one 8-bit sample
//   per request. Output channel: out_valid_o / out_stall_i with sample_out_o.
//   Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
//   (0 exposure_stops, 1 offset_level, 2 gamma_value, 3 ignored). Write only
//   while no request is in flight.
// Stages: 6 gain stages, 26 log2 stages (normalize plus 24 squarings), 40 divider
//   stages (an input register, then one quotient bit each), 27 power stages and
//   the output register.
// Throughput: one request per clock unless frozen; every stage holds one request.
// Reset: registers go to exposure 0, offset 0, gamma 1.0; all valid bits clear.
// Stall: the output has a two-entry buffer. The pipeline keeps moving while a
//   result waits; it freezes as a whole only when the buffer is full and the
//   receiver stalls, and then in_stall_o is raised. Nothing is lost or doubled.
module exposure_offset_gamma_map_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [eogm_pkg::SampleBits-1:0]      sample_in_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [eogm_pkg::SampleBits-1:0]      sample_out_o,
  input  logic                                 cfg_we_i,
  input  logic [eogm_pkg::IdxW-1:0]            cfg_idx_i,
  input  logic [eogm_pkg::GamW-1:0]            cfg_wdata_i
);
  import eogm_pkg::*;

  // configuration
  logic signed [ExpW-1:0] exposure_q;
  logic signed [OffW-1:0] offset_q;
  logic [GamW-1:0]        gamma_q;

  // pipeline hookup
  logic                   en;
  ctl_t                   gain_ctl, log_ctl, div_ctl;
  logic [XW-1:0]          gain_x;
  logic signed [LW-1:0]   log_l;
  logic [DW-1:0]          div_q;
  logic                   div_neg;
  logic                   pipe_valid;
  logic [SampleBits-1:0]  pipe_sample;

  // output buffer: head drives the port, skid catches one more
  logic                   head_valid_q, head_valid_d;
  logic [SampleBits-1:0]  head_q, head_d;
  logic                   skid_valid_q, skid_valid_d;
  logic [SampleBits-1:0]  skid_q, skid_d;
  logic                   pop, push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exposure_q <= '0;
      offset_q   <= '0;
      gamma_q    <= GamW'(1) << FracBits;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_EXPOSURE: exposure_q <= cfg_wdata_i[ExpW-1:0];
        REG_OFFSET:   offset_q   <= cfg_wdata_i[OffW-1:0];
        REG_GAMMA:    gamma_q    <= cfg_wdata_i[GamW-1:0];
        default:      ;
      endcase
    end
  end

  // whole pipeline advances unless the buffer is full and not draining
  assign pop        = head_valid_q & ~out_stall_i;
  assign en         = ~skid_valid_q | pop;
  assign push       = pipe_valid & en;
  assign in_stall_o = ~en;

  eogm_gain u_gain (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (in_valid_i),
    .sample_i   (sample_in_i),
    .exposure_i (exposure_q),
    .offset_i   (offset_q),
    .ctl_o      (gain_ctl),
    .x_o        (gain_x)
  );

  eogm_log2 u_log2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (gain_ctl),
    .x_i    (gain_x),
    .ctl_o  (log_ctl),
    .l_o    (log_l)
  );

  eogm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .ctl_i   (log_ctl),
    .l_i     (log_l),
    .gamma_i (gamma_q),
    .ctl_o   (div_ctl),
    .q_o     (div_q),
    .neg_o   (div_neg)
  );

  eogm_pow u_pow (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .ctl_i    (div_ctl),
    .q_i      (div_q),
    .neg_i    (div_neg),
    .valid_o  (pipe_valid),
    .sample_o (pipe_sample)
  );

  always_comb begin
    head_valid_d = head_valid_q;
    head_d       = head_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (pop) begin
      if (skid_valid_q) begin
        head_valid_d = 1'b1;
        head_d       = skid_q;
        skid_valid_d = push;
        skid_d       = pipe_sample;
      end else begin
        head_valid_d = push;
        head_d       = pipe_sample;
      end
    end else if (push) begin
      if (head_valid_q) begin
        skid_valid_d = 1'b1;
        skid_d       = pipe_sample;
      end else begin
        head_valid_d = 1'b1;
        head_d       = pipe_sample;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      head_valid_q <= head_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

  assign out_valid_o  = head_valid_q;
  assign sample_out_o = head_q;

`ifndef SYNTH
  a_skid_behind_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> head_valid_q)
    else $error("skid entry held without a head entry");

  a_freeze_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (skid_valid_q && out_stall_i))
    else $error("pipeline frozen while the output buffer can take more");

  a_drain_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !skid_valid_q && !pipe_valid) |=> !head_valid_q)
    else $error("output stayed valid after its last result was taken");
`endif

endmodule

/* rtl/core/eogm_gain.sv */
// Gain stages: v * 2^exposure / 255 with rounding, then offset add.
module eogm_gain (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  valid_i,
  input  logic [eogm_pkg::SampleBits-1:0]       sample_i,
  input  logic signed [eogm_pkg::ExpW-1:0]      exposure_i,
  input  logic signed [eogm_pkg::OffW-1:0]      offset_i,
  output eogm_pkg::ctl_t                        ctl_o,
  output logic [eogm_pkg::XW-1:0]               x_o
);
  import eogm_pkg::*;

  localparam int NTerm = TW / SampleBits + 1;

  ctl_t                   ctl1_q, ctl2_q, ctl3_q, ctl4_q, ctl5_q, ctl6_q;
  logic [SampleBits-1:0]  v1_q;
  logic [YW-1:0]          e1_q;
  logic signed [EiW-1:0]  ei1_q, ei2_q;
  logic [PW-1:0]          p2_q;
  logic [TW-1:0]          t3_d, t3_q, t4_q;
  logic [TW:0]            s4_d;
  logic [GW-1:0]          q4_q, g5_d, g5_q;
  logic [TW-1:0]          r5;
  logic [EiW-1:0]         rsh;
  logic signed [XSW-1:0]  xs6_d;
  logic [XW-1:0]          x6_q;
  ctl_t                   ctl6_d;
  ctl_t                   ctl_in;

  assign ctl_in = '{valid: valid_i, ovr: OVR_NONE};

  // negative exponent: round to nearest of p / (255 * 2^s) as a shift then /255
  always_comb begin
    rsh = EiW'(-ei2_q);
    if (!ei2_q[EiW-1]) begin
      t3_d = (TW'(p2_q) << ei2_q[EiW-2:0]) + TW'(MaxV / 2);
    end else begin
      t3_d = (TW'(p2_q) + (TW'(MaxV) << (rsh - EiW'(1)))) >> rsh;
    end
  end

  // T * 256/255 by a geometric sum; low by at most one quotient step
  always_comb begin
    s4_d = '0;
    for (int k = 0; k < NTerm; k++) begin
      s4_d = s4_d + (TW + 1)'(t3_q >> (SampleBits * k));
    end
  end

  always_comb begin
    r5   = t4_q - ((TW'(q4_q) << SampleBits) - TW'(q4_q));
    g5_d = (r5 >= TW'(MaxV)) ? q4_q + GW'(1) : q4_q;
  end

  always_comb begin
    xs6_d  = $signed({1'b0, g5_q})
           + ($signed({{(XSW-OffW){offset_i[OffW-1]}}, offset_i}) <<< (QB - FracBits));
    ctl6_d = ctl5_q;
    if (xs6_d <= 0) ctl6_d.ovr = OVR_ZERO;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '{valid: 1'b0, ovr: OVR_NONE};
      ctl2_q <= '{valid: 1'b0, ovr: OVR_NONE};
      ctl3_q <= '{valid: 1'b0, ovr: OVR_NONE};
      ctl4_q <= '{valid: 1'b0, ovr: OVR_NONE};
      ctl5_q <= '{valid: 1'b0, ovr: OVR_NONE};
      ctl6_q <= '{valid: 1'b0, ovr: OVR_NONE};
    end else if (en_i) begin
      ctl1_q <= ctl_in;
      ctl2_q <= ctl1_q;
      ctl3_q <= ctl2_q;
      ctl4_q <= ctl3_q;
      ctl5_q <= ctl4_q;
      ctl6_q <= ctl6_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v1_q  <= sample_i;
      e1_q  <= ExpTab[exposure_i[FracBits-1:0]];
      ei1_q <= exposure_i[ExpW-1:FracBits];
      p2_q  <= PW'(v1_q) * PW'(e1_q);
      ei2_q <= ei1_q;
      t3_q  <= t3_d;
      t4_q  <= t3_q;
      q4_q  <= s4_d[TW:SampleBits];
      g5_q  <= g5_d;
      x6_q  <= xs6_d[XW-1:0];
    end
  end

  assign ctl_o = ctl6_q;
  assign x_o   = x6_q;

endmodule

/* rtl/core/eogm_log2.sv */
// Log2 stages: leading-one normalize, then one squaring per fraction bit.
module eogm_log2 (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  eogm_pkg::ctl_t                       ctl_i,
  input  logic [eogm_pkg::XW-1:0]              x_i,
  output eogm_pkg::ctl_t                       ctl_o,
  output logic signed [eogm_pkg::LW-1:0]       l_o
);
  import eogm_pkg::*;

  ctl_t                 ctla_q;
  logic [XW-1:0]        xa_q;
  logic [NW-1:0]        na_d, na_q;
  logic [XW+QB-1:0]     wide;

  ctl_t                 ctl_q [LB+1];
  logic [MW-1:0]        z_q   [LB+1];
  logic [LB-1:0]        fr_q  [LB+1];
  logic signed [IW-1:0] int_q [LB+1];

  always_comb begin
    na_d = '0;
    for (int i = 0; i < XW; i++) begin
      if (x_i[i]) na_d = NW'(i);
    end
  end

  assign wide = {xa_q, QB'(0)} >> na_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctla_q   <= '{valid: 1'b0, ovr: OVR_NONE};
      ctl_q[0] <= '{valid: 1'b0, ovr: OVR_NONE};
    end else if (en_i) begin
      ctla_q   <= ctl_i;
      ctl_q[0] <= ctla_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xa_q     <= x_i;
      na_q     <= na_d;
      z_q[0]   <= wide[QB:0];
      fr_q[0]  <= '0;
      int_q[0] <= $signed(IW'(na_q)) - $signed(IW'(QB));
    end
  end

  for (genvar k = 0; k < LB; k++) begin : g_sq
    logic [2*MW-1:0] sq;
    logic [YW-1:0]   zs;
    logic            bit_d;

    assign sq    = (2*MW)'(z_q[k]) * (2*MW)'(z_q[k]) + (2*MW)'(HalfQ);
    assign zs    = sq[QB+YW-1:QB];
    assign bit_d = zs[QB+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[k+1] <= '{valid: 1'b0, ovr: OVR_NONE};
      end else if (en_i) begin
        ctl_q[k+1] <= ctl_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        z_q[k+1]   <= bit_d ? zs[QB+1:1] : zs[QB:0];
        fr_q[k+1]  <= {fr_q[k][LB-2:0], bit_d};
        int_q[k+1] <= int_q[k];
      end
    end
  end

  assign ctl_o = ctl_q[LB];
  assign l_o   = $signed({int_q[LB], fr_q[LB]});

endmodule

/* rtl/core/eogm_div.sv */
// Restoring divider, one quotient bit per stage: |L| * 2^F / gamma.
module eogm_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  eogm_pkg::ctl_t                       ctl_i,
  input  logic signed [eogm_pkg::LW-1:0]       l_i,
  input  logic [eogm_pkg::GamW-1:0]            gamma_i,
  output eogm_pkg::ctl_t                       ctl_o,
  output logic [eogm_pkg::DW-1:0]              q_o,
  output logic                                 neg_o
);
  import eogm_pkg::*;

  logic [GamW-1:0] g;
  logic [LW-1:0]   mag;

  ctl_t            ctl_q [DW+1];
  logic [DW-1:0]   d_q   [DW+1];
  logic [GamW-1:0] rem_q [DW+1];
  logic            neg_q [DW+1];

  // gamma of zero acts as one LSB
  assign g   = (gamma_i == '0) ? GamW'(1) : gamma_i;
  assign mag = l_i[LW-1] ? LW'(-l_i) : LW'(l_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q[0] <= '{valid: 1'b0, ovr: OVR_NONE};
    end else if (en_i) begin
      ctl_q[0] <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q[0]   <= {mag, FracBits'(0)};
      rem_q[0] <= '0;
      neg_q[0] <= l_i[LW-1];
    end
  end

  for (genvar k = 0; k < DW; k++) begin : g_bit
    logic [GamW:0] t;
    logic          ge;

    assign t  = {rem_q[k], d_q[k][DW-1]};
    assign ge = (t >= {1'b0, g});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[k+1] <= '{valid: 1'b0, ovr: OVR_NONE};
      end else if (en_i) begin
        ctl_q[k+1] <= ctl_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= ge ? GamW'(t - {1'b0, g}) : t[GamW-1:0];
        d_q[k+1]   <= {d_q[k][DW-2:0], ge};
        neg_q[k+1] <= neg_q[k];
      end
    end
  end

  assign ctl_o = ctl_q[DW];
  assign q_o   = d_q[DW];
  assign neg_o = neg_q[DW];

endmodule

/* rtl/core/eogm_pow.sv */
// Power stages: exp2 of the scaled log, range checks, shift and scale to 0..255.
module eogm_pow (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  eogm_pkg::ctl_t                       ctl_i,
  input  logic [eogm_pkg::DW-1:0]              q_i,
  input  logic                                 neg_i,
  output logic                                 valid_o,
  output logic [eogm_pkg::SampleBits-1:0]      sample_o
);
  import eogm_pkg::*;

  localparam logic signed [LiW-1:0] LiTop = LiW'(8);
  localparam logic signed [LiW-1:0] LiBot = -LiW'(40);

  logic signed [DW:0]    lp;
  logic signed [LiW-1:0] li;
  ctl_t                  ctl0_d;

  ctl_t                  ctl_q [LB+1];
  logic [YW-1:0]         y_q   [LB+1];
  logic [LB-1:0]         f_q   [LB+1];
  logic signed [SHW-1:0] sh_q  [LB+1];

  ctl_t                  ctls_q, ctlr_q;
  logic [YSW-1:0]        ys_d, ys_q;
  logic [SHW-1:0]        amt;
  logic [RW-1:0]         r;
  logic [SampleBits-1:0] out_d, out_q;

  always_comb begin
    lp     = neg_i ? -$signed({1'b0, q_i}) : $signed({1'b0, q_i});
    li     = lp[DW:LB];
    ctl0_d = ctl_i;
    if (ctl_i.ovr == OVR_NONE) begin
      if (li >= LiTop) ctl0_d.ovr = OVR_FULL;
      else if (li < LiBot) ctl0_d.ovr = OVR_ZERO;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q[0] <= '{valid: 1'b0, ovr: OVR_NONE};
    end else if (en_i) begin
      ctl_q[0] <= ctl0_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_q[0]  <= YW'(1) << QB;
      f_q[0]  <= lp[LB-1:0];
      sh_q[0] <= li[SHW-1:0];
    end
  end

  for (genvar k = 0; k < LB; k++) begin : g_exp
    logic [2*YW-1:0] pr;

    assign pr = (2*YW)'(y_q[k]) * (2*YW)'(Roots[k]) + (2*YW)'(HalfQ);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[k+1] <= '{valid: 1'b0, ovr: OVR_NONE};
      end else if (en_i) begin
        ctl_q[k+1] <= ctl_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        y_q[k+1]  <= f_q[k][LB-1-k] ? pr[QB+YW-1:QB] : y_q[k];
        f_q[k+1]  <= f_q[k];
        sh_q[k+1] <= sh_q[k];
      end
    end
  end

  // power-of-two part, truncating on the right
  always_comb begin
    amt = SHW'(-sh_q[LB]);
    if (!sh_q[LB][SHW-1]) ys_d = YSW'(y_q[LB]) << sh_q[LB][2:0];
    else ys_d = YSW'(y_q[LB]) >> amt;
  end

  always_comb begin
    r = (({ys_q, SampleBits'(0)} - RW'(ys_q)) + RW'(HalfQ)) >> QB;
    case (ctls_q.ovr)
      OVR_ZERO: out_d = '0;
      OVR_FULL: out_d = SampleBits'(MaxV);
      default:  out_d = (r > RW'(MaxV)) ? SampleBits'(MaxV) : r[SampleBits-1:0];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctls_q <= '{valid: 1'b0, ovr: OVR_NONE};
      ctlr_q <= '{valid: 1'b0, ovr: OVR_NONE};
    end else if (en_i) begin
      ctls_q <= ctl_q[LB];
      ctlr_q <= ctls_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ys_q  <= ys_d;
      out_q <= out_d;
    end
  end

  assign valid_o  = ctlr_q.valid;
  assign sample_o = out_q;

endmodule
